/* rtl/ptt_pkg.sv */
// Shared types and codes for the periodic timer table.
package ptt_pkg;

    // Command codes carried on s_tuser
    localparam logic [1:0] CMD_CREATE = 2'd0;
    localparam logic [1:0] CMD_START  = 2'd1;
    localparam logic [1:0] CMD_STOP   = 2'd2;
    localparam logic [1:0] CMD_TICK   = 2'd3;

    // Result kinds carried on m_tuser
    localparam logic [1:0] KIND_CREATED = 2'd0;
    localparam logic [1:0] KIND_FULL    = 2'd1;
    localparam logic [1:0] KIND_FIRED   = 2'd2;

    // Most fire transactions reported for one tick
    localparam int unsigned RES_MAX = 16;
    localparam int unsigned RES_W   = 5;

    localparam int unsigned IN_DATA_W  = 104;
    localparam int unsigned OUT_DATA_W = 40;

    // Control from the sequencer to every cell
    typedef struct packed {
        logic        create;   // load new channel into this cell
        logic        set_act;  // write active flag
        logic        act_val;  // value for active flag
        logic        step;     // token moves one cell
        logic        advance;  // walk proceeds this cycle
    } cell_ctl_t;

    // Fire request from the cell holding the token
    typedef struct packed {
        logic        emit;
        logic [3:0]  chan;
        logic [31:0] addr;
    } cell_out_t;

endpackage

/* rtl/ptt_cell.sv */
// One timer channel: stored interval, last fire time, address and walk token.
module ptt_cell import ptt_pkg::*; #(
    parameter int unsigned IDX = 0
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cell_ctl_t   ctl,
    input  logic [31:0] wr_addr,
    input  logic [31:0] wr_period,
    input  logic [31:0] now,
    input  logic        tok_in,
    output logic        tok_out,
    output cell_out_t   fire
);

    localparam logic [3:0] CHAN_ID = 4'(IDX % 16);

    logic        tok_reg;
    logic        active_reg;
    logic [31:0] addr_reg;
    logic [31:0] period_reg;
    logic [31:0] last_reg;
    logic [31:0] elapsed;
    logic        due;

    // Wrapped elapsed time against interval
    assign elapsed = now - last_reg;
    assign due     = tok_reg && active_reg && (elapsed >= period_reg);

    // Fire request is zero unless this cell emits, so the row can be OR-gathered
    assign tok_out   = tok_reg;
    assign fire.emit = due && (addr_reg != 32'd0);
    assign fire.chan = fire.emit ? CHAN_ID : 4'd0;
    assign fire.addr = fire.emit ? addr_reg : 32'd0;

    // Token and active flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg    <= 1'b0;
            active_reg <= 1'b0;
        end else begin
            if (ctl.step) begin
                tok_reg <= tok_in;
            end
            if (ctl.create) begin
                active_reg <= 1'b0;
            end else if (ctl.set_act) begin
                active_reg <= ctl.act_val;
            end
        end
    end

    // Channel payload
    always_ff @(posedge aclk) begin
        if (ctl.create) begin
            addr_reg   <= wr_addr;
            period_reg <= wr_period;
            last_reg   <= 32'd0;
        end else if (ctl.advance && due) begin
            last_reg <= now;
        end
    end

endmodule

/* rtl/periodic_task_timer_table_unit.sv */
// Top level of the periodic timer table: command intake, walk sequencer, result staging.
//
// Usage: commands arrive on the s_ channel, cmd on s_tuser, the rest on s_tdata.
// Create returns one transaction (created or table full) with m_tlast set.
// Start and stop update a channel's active flag and return nothing.
// Tick passes a token down the row of MAX_TASKS cells, one cell per cycle unless stalled;
// each due channel with a nonzero address yields a fired transaction (at most RES_MAX
// per tick), the final one marked by m_tlast. A tick that fires nothing is silent.
// The create result is registered and appears in the cycle after acceptance. A tick
// walks the token over the cell row, then flushes the hold stage, and the next
// command is accepted after that. Create, start and stop are accepted while idle and
// the output register is free.
// A fired result waits in a one-entry hold stage so that m_tlast can be set
// on the last one; when the token-holding cell fires while hold and output are full
// and the receiver stalls, the token stops in place until the output drains.
// Reset (aresetn low, synchronous) empties the table and clears all flags.
module periodic_task_timer_table_unit import ptt_pkg::*; #(
    parameter int unsigned MAX_TASKS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // handle[3:0], target_addr[35:4], period[67:36], now[99:68], zero fill
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // cmd[1:0]
    input  logic [1:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // chan[3:0], fire_addr[35:4], zero fill
    output logic [OUT_DATA_W-1:0] m_tdata,
    // kind[1:0]
    output logic [1:0]            m_tuser,
    output logic                  m_tlast
);

    localparam int unsigned CNT_W = $clog2(MAX_TASKS + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WALK  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [31:0]           now_reg, now_next;
    logic [RES_W-1:0]      n_reg, n_next;
    logic                  hold_v_reg, hold_v_next;
    logic [3:0]            hold_chan_reg, hold_chan_next;
    logic [31:0]           hold_addr_reg, hold_addr_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [1:0]            m_tuser_reg, m_tuser_next;
    logic                  m_tlast_reg, m_tlast_next;

    logic [1:0]            cmd;
    logic [3:0]            handle;
    logic [31:0]           in_addr;
    logic [31:0]           in_period;
    logic [31:0]           in_now;
    logic                  s_acc;
    logic                  out_free;
    logic                  create_ok;
    logic                  ss_ok;
    logic                  start_walk;
    logic                  emit_ok;
    logic                  stall;
    logic                  advance;
    logic                  walk_done;
    cell_out_t             fire_any;

    logic [MAX_TASKS-1:0]  tok;
    cell_out_t             fire_vec [MAX_TASKS];
    cell_ctl_t             ctl_vec  [MAX_TASKS];

    // Field unpacking
    assign cmd       = s_tuser;
    assign handle    = s_tdata[3:0];
    assign in_addr   = s_tdata[35:4];
    assign in_period = s_tdata[67:36];
    assign in_now    = s_tdata[99:68];

    assign out_free   = !m_tvalid_reg || m_tready;
    assign s_tready   = (state_reg == ST_IDLE) && out_free;
    assign s_acc      = s_tvalid && s_tready;
    assign create_ok  = s_acc && (cmd == CMD_CREATE) && (cnt_reg < CNT_W'(MAX_TASKS));
    assign ss_ok      = s_acc && ((cmd == CMD_START) || (cmd == CMD_STOP))
                        && (7'(handle) < 7'(cnt_reg));
    assign start_walk = s_acc && (cmd == CMD_TICK);

    // Gather the single fire request of the token-holding cell
    always_comb begin
        fire_any = '0;
        for (int i = 0; i < MAX_TASKS; i++) begin
            fire_any = fire_any | fire_vec[i];
        end
    end

    assign emit_ok   = fire_any.emit && (n_reg < RES_W'(RES_MAX));
    assign stall     = emit_ok && hold_v_reg && !out_free;
    assign advance   = (state_reg == ST_WALK) && !stall;
    assign walk_done = advance && tok[MAX_TASKS-1];

    // Cell row
    for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
        logic tok_in_w;
        if (i == 0) begin : g_head
            assign tok_in_w = start_walk;
        end else begin : g_link
            assign tok_in_w = tok[i-1];
        end

        assign ctl_vec[i].create  = create_ok && (cnt_reg == CNT_W'(i));
        assign ctl_vec[i].set_act = ss_ok && (7'(handle) == 7'(i));
        assign ctl_vec[i].act_val = (cmd == CMD_START);
        assign ctl_vec[i].step    = start_walk || advance;
        assign ctl_vec[i].advance = advance;

        ptt_cell #(
            .IDX (i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctl       (ctl_vec[i]),
            .wr_addr   (in_addr),
            .wr_period (in_period),
            .now       (now_reg),
            .tok_in    (tok_in_w),
            .tok_out   (tok[i]),
            .fire      (fire_vec[i])
        );
    end

    // Sequencer, hold stage and output register
    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        now_next       = now_reg;
        n_next         = n_reg;
        hold_v_next    = hold_v_reg;
        hold_chan_next = hold_chan_reg;
        hold_addr_next = hold_addr_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;
        m_tlast_next   = m_tlast_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc && (cmd == CMD_CREATE)) begin
                    m_tvalid_next = 1'b1;
                    m_tlast_next  = 1'b1;
                    if (create_ok) begin
                        m_tuser_next = KIND_CREATED;
                        m_tdata_next = {4'd0, 32'd0, 4'(cnt_reg)};
                        cnt_next     = cnt_reg + 1'b1;
                    end else begin
                        m_tuser_next = KIND_FULL;
                        m_tdata_next = '0;
                    end
                end
                if (start_walk) begin
                    now_next    = in_now;
                    n_next      = '0;
                    hold_v_next = 1'b0;
                    state_next  = ST_WALK;
                end
            end
            ST_WALK: begin
                if (advance && emit_ok) begin
                    if (hold_v_reg) begin
                        m_tvalid_next = 1'b1;
                        m_tlast_next  = 1'b0;
                        m_tuser_next  = KIND_FIRED;
                        m_tdata_next  = {4'd0, hold_addr_reg, hold_chan_reg};
                    end
                    hold_v_next    = 1'b1;
                    hold_chan_next = fire_any.chan;
                    hold_addr_next = fire_any.addr;
                    n_next         = n_reg + 1'b1;
                end
                if (walk_done) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!hold_v_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tlast_next  = 1'b1;
                    m_tuser_next  = KIND_FIRED;
                    m_tdata_next  = {4'd0, hold_addr_reg, hold_chan_reg};
                    hold_v_next   = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            n_reg        <= '0;
            hold_v_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            n_reg        <= n_next;
            hold_v_reg   <= hold_v_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        now_reg       <= now_next;
        hold_chan_reg <= hold_chan_next;
        hold_addr_reg <= hold_addr_next;
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
        m_tlast_reg   <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef SYNTHESIS
    // At most one cell holds the walk token
    assert property (@(posedge aclk) disable iff (!aresetn) $onehot0(tok))
        else $error("more than one walk token in the cell row");

    // No token outside a walk
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (tok == '0))
        else $error("walk token present while idle");

    // Hold stage is empty whenever commands are taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !hold_v_reg)
        else $error("pending fire left in hold stage");

    // Reported fires per tick bounded
    assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= RES_W'(RES_MAX))
        else $error("fire count exceeds report limit");
`endif

endmodule
